// ----- design/selsort_pkg.sv -----
// Shared constants and types for the selection sorter.
`default_nettype none

package selsort_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 64;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_SCAN,
        S_SWAP
    } sort_state_t;

endpackage

`default_nettype wire

// ----- design/selection_sorter.sv -----
// Selection sorter: collects a set of signed values, sorts it in memory, streams it out.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+--------------------------------------
//   input    | in        | in_valid/in_stall | value, is_final
//   output   | out       | out_valid/out_stall | sorted_value, is_final_res, overflow
//
// Collection accepts one request per cycle; the block stalls its input from the final
// request until the last sorted value has been loaded into the output register.
// Each sorted value costs one pass over the unsorted tail through the single memory
// read port, (count - pos) reads, followed by the swap write. No clearing pass is
// needed after reset.
// A result waiting in the output register does not stop the next scan; only loading
// the following result waits on out_stall.
`default_nettype none

module selection_sorter
    import selsort_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire logic                     is_final,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      sorted_value,
    output logic                          is_final_res,
    output logic                          overflow
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    sort_state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          issue_on_reg, issue_on_next;
    logic          rvalid_reg;
    logic [AW-1:0] ridx_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    logic [AW-1:0] best_reg, best_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_val_reg, out_val_next;
    logic                     out_fin_reg, out_fin_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;

    logic [CW-1:0] count_m1;
    logic [AW-1:0] last_idx;
    logic          in_acc;
    logic          out_free;
    logic          has_room;
    logic          scan_done;
    logic          load_out;
    logic          pass_last;

    assign count_m1  = count_reg - CW'(1);
    assign last_idx  = count_m1[AW-1:0];
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign has_room  = count_reg < CW'(DEPTH);
    assign scan_done = rvalid_reg && (ridx_reg == last_idx);
    assign pass_last = pos_reg == last_idx;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (in_acc && is_final)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                if (out_free)
                begin
                    state_next = pass_last ? S_COLLECT : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = value;
        load_out  = 1'b0;
        case (state_reg)
            S_COLLECT:
            begin
                in_stall = 1'b0;
                mem_we   = in_valid && has_room;
            end
            S_SCAN:
            begin
                in_stall = 1'b1;
            end
            S_SWAP:
            begin
                // The old head of the tail moves to where the minimum was found.
                mem_we    = out_free;
                mem_waddr = best_reg;
                mem_wdata = cur_reg;
                load_out  = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        rd_idx_next   = rd_idx_reg;
        issue_on_next = issue_on_reg;
        min_next      = min_reg;
        cur_next      = cur_reg;
        best_next     = best_reg;

        if (state_reg == S_COLLECT && in_acc)
        begin
            if (has_room)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (is_final)
            begin
                pos_next      = '0;
                rd_idx_next   = '0;
                issue_on_next = 1'b1;
            end
        end

        if (state_reg == S_SCAN)
        begin
            if (issue_on_reg)
            begin
                if (rd_idx_reg == last_idx)
                begin
                    issue_on_next = 1'b0;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + AW'(1);
                end
            end
            if (rvalid_reg)
            begin
                if (ridx_reg == pos_reg)
                begin
                    cur_next  = rd_data_reg;
                    min_next  = rd_data_reg;
                    best_next = ridx_reg;
                end
                else if (rd_data_reg < min_reg)
                begin
                    min_next  = rd_data_reg;
                    best_next = ridx_reg;
                end
            end
        end

        if (state_reg == S_SWAP && out_free)
        begin
            if (pass_last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                pos_next      = pos_reg + AW'(1);
                rd_idx_next   = pos_reg + AW'(1);
                issue_on_next = 1'b1;
            end
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_val_next   = out_val_reg;
        out_fin_next   = out_fin_reg;
        out_ovf_next   = out_ovf_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_val_next   = min_reg;
            out_fin_next   = pass_last;
            out_ovf_next   = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            issue_on_reg  <= 1'b0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            issue_on_reg  <= issue_on_next;
            rvalid_reg    <= (state_reg == S_SCAN) && issue_on_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        rd_idx_reg  <= rd_idx_next;
        ridx_reg    <= rd_idx_reg;
        min_reg     <= min_next;
        cur_reg     <= cur_next;
        best_reg    <= best_next;
        out_val_reg <= out_val_next;
        out_fin_reg <= out_fin_next;
        out_ovf_reg <= out_ovf_next;
    end

    // Element memory. The swap write and the next pass's reads never share a cycle,
    // because the next pass issues its first read only after leaving the swap state.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_val_reg;
    assign is_final_res = out_fin_reg;
    assign overflow     = out_ovf_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count exceeds capacity");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_COLLECT |-> count_reg != '0)
        else $error("sorting an empty set");

    a_read_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg |-> (ridx_reg >= pos_reg) && (ridx_reg <= last_idx))
        else $error("read returned outside the unsorted tail");

    a_swap_in_tail: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWAP |-> (best_reg >= pos_reg) && (best_reg <= last_idx))
        else $error("minimum index outside the unsorted tail");

    a_no_read_in_swap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SWAP |-> !issue_on_reg && !rvalid_reg)
        else $error("read in flight during the swap write");
`endif

endmodule

`default_nettype wire

// ----- dv/selection_sorter_tb.sv -----
// Self-checking testbench for the selection sorter: directed and random sets with random idling.
module selection_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import selsort_pkg::*;

    localparam int SET_CAP        = DEPTH_DEFAULT;
    localparam int RAND_ITEMS     = 12;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 10000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_EDGES,
        MIX_ANY
    } value_mix_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     is_final;
        int unsigned              gap;
    } sort_request_t;

    typedef struct {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     is_final_res;
        logic                     overflow;
    } sorted_result_t;

    logic                     clk          = 1'b0;
    logic                     rst_n        = 1'b0;
    logic                     in_valid     = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] value        = '0;
    logic                     is_final     = 1'b0;
    logic                     out_valid;
    logic                     out_stall    = 1'b0;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     is_final_res;
    logic                     overflow;

    selection_sorter #(
        .DEPTH(SET_CAP)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .is_final(is_final),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sorted_value(sorted_value),
        .is_final_res(is_final_res),
        .overflow(overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stimulus waiting to be driven and sorted values waiting to come out.
    sort_request_t  pending_reqs[$];
    sorted_result_t expected_sorted[$];

    // Predictor copy of the set being collected.
    logic signed [DATA_W-1:0] held_vals[SET_CAP];
    int unsigned              held_count    = 0;
    logic                     held_overflow = 1'b0;

    int unsigned mismatches    = 0;
    int unsigned req_count     = 0;
    int unsigned sets_done     = 0;
    int unsigned overflow_sets = 0;
    int unsigned checked       = 0;
    int unsigned idle_cycles   = 0;

    // Handshake outcomes sampled at the rising edge, used by the drivers.
    bit in_took  = 1'b0;
    bit out_took = 1'b0;
    bit out_seen = 1'b0;

    // Feeds the expected sorted values of a set once its final request is taken.
    task automatic predict_request(input logic signed [DATA_W-1:0] v, input logic fin);
        logic signed [DATA_W-1:0] ordered[SET_CAP];
        logic signed [DATA_W-1:0] key;
        sorted_result_t           res;
        int                       n;
        int                       i;
        int                       j;
        if (held_count < SET_CAP)
        begin
            held_vals[held_count] = v;
            held_count++;
        end
        else
            held_overflow = 1'b1;
        if (fin)
        begin
            n = held_count;
            for (i = 0; i < n; i++)
                ordered[i] = held_vals[i];
            for (i = 1; i < n; i++)
            begin
                key = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > key)
                begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = key;
            end
            for (i = 0; i < n; i++)
            begin
                res.sorted_value = ordered[i];
                res.is_final_res = (i == n - 1);
                res.overflow     = held_overflow;
                expected_sorted.push_back(res);
            end
            sets_done++;
            if (held_overflow)
                overflow_sets++;
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(input value_mix_t mix);
        if (mix == MIX_ANY)
            mix = value_mix_t'($urandom_range(0, 2));
        case (mix)
            MIX_WIDE:   return $urandom;
            MIX_NARROW: return $signed($urandom_range(0, 8)) - 4;
            default:
                case ($urandom_range(0, 3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    task automatic add_request(input logic signed [DATA_W-1:0] v, input logic fin,
                               input bit calm);
        sort_request_t req;
        req.value    = v;
        req.is_final = fin;
        req.gap      = calm ? 0 : $urandom_range(0, 17);
        pending_reqs.push_back(req);
    endtask

    task automatic add_set(input int size, input value_mix_t mix, input bit calm);
        int i;
        for (i = 0; i < size; i++)
            add_request(pick_value(mix), i == size - 1, calm);
    endtask

    // Monitor: predicts on every taken request and checks every taken result.
    always @(posedge clk)
    begin
        sorted_result_t want;
        in_took  = rst_n && in_valid && !in_stall;
        out_took = rst_n && out_valid && !out_stall;
        out_seen = rst_n && out_valid;
        if (in_took)
        begin
            req_count++;
            predict_request(value, is_final);
        end
        if (out_took)
        begin
            if (expected_sorted.size() == 0)
            begin
                $error("sorted_value: expected nothing, got %0d", sorted_value);
                mismatches++;
            end
            else
            begin
                want = expected_sorted.pop_front();
                checked++;
                if (sorted_value !== want.sorted_value)
                begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.sorted_value, sorted_value);
                    mismatches++;
                end
                if (is_final_res !== want.is_final_res)
                begin
                    $error("is_final_res: expected %0b, got %0b",
                           want.is_final_res, is_final_res);
                    mismatches++;
                end
                if (overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                    mismatches++;
                end
            end
        end
    end

    // Request driver: waits out each request's gap, then holds it until taken.
    sort_request_t cur_req;
    bit            staged   = 1'b0;
    bit            feeding  = 1'b0;
    int unsigned   gap_left = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (feeding && in_took)
                feeding = 1'b0;
            if (!feeding)
            begin
                if (!staged && pending_reqs.size() > 0)
                begin
                    cur_req  = pending_reqs.pop_front();
                    staged   = 1'b1;
                    gap_left = cur_req.gap;
                end
                if (staged)
                begin
                    if (gap_left == 0)
                    begin
                        feeding = 1'b1;
                        staged  = 1'b0;
                        value    <= cur_req.value;
                        is_final <= cur_req.is_final;
                    end
                    else
                        gap_left--;
                end
            end
        end
        in_valid <= feeding;
    end

    // Result-side stall: a fresh stall length for each result, with calm stretches.
    int unsigned stall_left = 0;
    int unsigned calm_left  = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
            begin
                if (calm_left > 0)
                begin
                    calm_left--;
                    stall_left = 0;
                end
                else if ($urandom_range(0, 24) == 0)
                begin
                    calm_left  = $urandom_range(10, 40);
                    stall_left = 0;
                end
                else
                    stall_left = $urandom_range(0, 17);
            end
            else if (out_seen && stall_left > 0)
                stall_left--;
        end
        out_stall <= (stall_left != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int rand_items;
        int size;
        int pick;
        rand_items = 0;

        // Single extremes, a reversed pair, a duplicate pair, a mixed set, a descending run.
        add_request(VAL_MIN, 1'b1, 1'b0);
        add_request(VAL_MAX, 1'b1, 1'b0);
        add_request(VAL_MAX, 1'b0, 1'b0);
        add_request(VAL_MIN, 1'b1, 1'b0);
        add_request(5, 1'b0, 1'b1);
        add_request(5, 1'b1, 1'b1);
        add_request(0, 1'b0, 1'b0);
        add_request(-1, 1'b0, 1'b0);
        add_request(1, 1'b0, 1'b0);
        add_request(VAL_MAX, 1'b0, 1'b0);
        add_request(VAL_MIN, 1'b0, 1'b0);
        add_request(-1, 1'b0, 1'b0);
        add_request(32'h5555_5555, 1'b0, 1'b0);
        add_request(32'hAAAA_AAAA, 1'b1, 1'b0);
        for (int k = 3; k >= -2; k--)
            add_request(k, k == -2, 1'b1);

        while (rand_items < RAND_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                size = $urandom_range(1, 6);
            else if (pick < 9)
                size = $urandom_range(7, 16);
            else
                size = $urandom_range(17, 40);
            if (size > RAND_ITEMS - rand_items)
                size = RAND_ITEMS - rand_items;
            add_set(size, value_mix_t'($urandom_range(0, 3)), $urandom_range(0, 3) == 0);
            rand_items += size;
        end

        // A set that exactly fills the store, one that overflows by a few requests
        // including its final one, then a small set to see the flag clear.
        add_set(SET_CAP, MIX_ANY, 1'b0);
        add_set(SET_CAP + $urandom_range(1, 4), MIX_WIDE, 1'b0);
        add_set(3, MIX_ANY, 1'b0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || staged || feeding)
            @(posedge clk);
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d requests in %0d sets, %0d of them past the %0d-entry store.",
                 req_count, sets_done, overflow_sets, SET_CAP);
        $display("Compared %0d sorted values with the predicted order.", checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- selection_sorter.f -----
design/selsort_pkg.sv
design/selection_sorter.sv
dv/selection_sorter_tb.sv
